/* sv/ssh_pkg.sv */
`timescale 1ns / 1ps
package ssh_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int STACK_DEPTH   = 16;
    localparam int IDX_W         = 8;
    localparam int FIDX_W        = 4;
    localparam int DEPTH_W       = 5;
    localparam int FADDR_W       = IDX_W + FIDX_W;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FRAME = 1'b1;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [1:0] OC_NEW  = 2'd0;
    localparam logic [1:0] OC_HIT  = 2'd1;
    localparam logic [1:0] OC_DROP = 2'd2;

    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_DIVIDER = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] frame_addr;
        logic [31:0] proc_id;
        logic        last_frame;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic        sample_due;
        logic [1:0]  outcome;
        logic [7:0]  slot_index;
        logic [63:0] slot_count;
        logic [63:0] recorded_samples;
        logic [63:0] dropped_samples;
    } out_t;

    // Work handed from the front to the back through the queue
    typedef struct packed {
        logic               is_tick;
        logic               due;
        logic [31:0]        hash;
        logic [31:0]        pid;
        logic [DEPTH_W-1:0] depth;
    } job_t;

    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
        logic [31:0] r;
        r = (h ^ v) * FNV_PRIME;
        return r;
    endfunction

endpackage

/* sv/ssh_queue.sv */
`timescale 1ns / 1ps
module ssh_queue
    import ssh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* sv/ssh_front.sv */
`timescale 1ns / 1ps
module ssh_front
    import ssh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    input  logic              enable,
    input  logic [15:0]       divider,
    input  logic              clear,
    output logic              push,
    output job_t              push_job,
    input  logic              q_full,
    input  logic              done,
    input  logic [FIDX_W-1:0] pend_idx,
    output logic [63:0]       pend_frame
);

    typedef enum logic {F_IDLE, F_HASH} fstate_t;

    fstate_t            state_reg;
    logic [15:0]        tick_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [31:0]        run_hash_reg;
    logic [31:0]        h_reg;
    logic               busy_reg;
    logic               first_reg;
    logic [2:0]         step_reg;
    logic [63:0]        addr_sh_reg;
    logic [31:0]        pid_reg;
    logic               last_reg;
    logic [63:0]        pend_reg [STACK_DEPTH];

    logic               accept;
    logic               is_frame;
    logic               room;
    logic [15:0]        div_eff;
    logic [15:0]        tick_inc;
    logic               due;
    logic [31:0]        operand;
    logic [31:0]        h_new;
    logic               hash_end;

    assign in_stall   = (state_reg != F_IDLE) || q_full || busy_reg;
    assign accept     = in_valid && !in_stall;
    assign is_frame   = (in_data.func == FUNC_FRAME);
    assign room       = (depth_reg < DEPTH_W'(STACK_DEPTH));
    assign div_eff    = (divider == 16'd0) ? 16'd1 : divider;
    assign tick_inc   = tick_reg + 16'd1;
    assign due        = enable && (tick_inc >= div_eff);
    assign operand    = first_reg ? pid_reg : {24'd0, addr_sh_reg[7:0]};
    assign h_new      = fnv_mix(h_reg, operand);
    assign hash_end   = (state_reg == F_HASH) && !first_reg && (step_reg == 3'd7);
    assign pend_frame = pend_reg[pend_idx];

    always_comb
    begin
        push     = 1'b0;
        push_job = '0;
        if (accept && !is_frame)
        begin
            push         = 1'b1;
            push_job.is_tick = 1'b1;
            push_job.due = due;
        end
        else if (accept && enable && !room && in_data.last_frame)
        begin
            push           = 1'b1;
            push_job.hash  = (run_hash_reg == 32'd0) ? 32'd1 : run_hash_reg;
            push_job.pid   = in_data.proc_id;
            push_job.depth = depth_reg;
        end
        else if (hash_end && last_reg)
        begin
            push           = 1'b1;
            push_job.hash  = (h_new == 32'd0) ? 32'd1 : h_new;
            push_job.pid   = pid_reg;
            push_job.depth = depth_reg + DEPTH_W'(1);
        end
    end

    // Frame store: written at the fill position, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && is_frame && enable && room)
        begin
            pend_reg[depth_reg[FIDX_W-1:0]] <= in_data.frame_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            tick_reg     <= 16'd0;
            depth_reg    <= '0;
            run_hash_reg <= FNV_BASIS;
            h_reg        <= FNV_BASIS;
            busy_reg     <= 1'b0;
            first_reg    <= 1'b0;
            step_reg     <= 3'd0;
            addr_sh_reg  <= 64'd0;
            pid_reg      <= 32'd0;
            last_reg     <= 1'b0;
        end
        else if (clear)
        begin
            state_reg    <= F_IDLE;
            tick_reg     <= 16'd0;
            depth_reg    <= '0;
            run_hash_reg <= FNV_BASIS;
            busy_reg     <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            case (state_reg)
                F_IDLE:
                begin
                    if (accept && !is_frame && enable)
                    begin
                        tick_reg <= due ? 16'd0 : tick_inc;
                    end
                    else if (accept && is_frame && enable)
                    begin
                        if (room)
                        begin
                            // start the byte walk; a fresh sample mixes the pid first
                            h_reg       <= (depth_reg == '0) ? FNV_BASIS : run_hash_reg;
                            first_reg   <= (depth_reg == '0);
                            step_reg    <= 3'd0;
                            addr_sh_reg <= in_data.frame_addr;
                            pid_reg     <= in_data.proc_id;
                            last_reg    <= in_data.last_frame;
                            state_reg   <= F_HASH;
                        end
                        else if (in_data.last_frame)
                        begin
                            depth_reg    <= '0;
                            run_hash_reg <= FNV_BASIS;
                            busy_reg     <= 1'b1;
                        end
                    end
                end
                F_HASH:
                begin
                    h_reg <= h_new;
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                    end
                    else
                    begin
                        addr_sh_reg <= addr_sh_reg >> 8;
                        step_reg    <= step_reg + 3'd1;
                    end
                    if (hash_end)
                    begin
                        state_reg <= F_IDLE;
                        if (last_reg)
                        begin
                            depth_reg    <= '0;
                            run_hash_reg <= FNV_BASIS;
                            busy_reg     <= 1'b1;
                        end
                        else
                        begin
                            depth_reg    <= depth_reg + DEPTH_W'(1);
                            run_hash_reg <= h_new;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/ssh_back.sv */
`timescale 1ns / 1ps
module ssh_back
    import ssh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              q_empty,
    input  job_t              q_head,
    output logic              pop,
    output logic [FIDX_W-1:0] pend_idx,
    input  logic [63:0]       pend_frame,
    output logic              done,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data
);

    typedef enum logic [2:0] {B_IDLE, B_READ, B_CMP, B_FRD, B_FCHK, B_COPY, B_EMIT} bstate_t;

    logic [31:0]        hash_mem [TABLE_ENTRIES];
    logic [31:0]        pid_mem  [TABLE_ENTRIES];
    logic [DEPTH_W-1:0] dep_mem  [TABLE_ENTRIES];
    logic [63:0]        hits_mem [TABLE_ENTRIES];
    logic [63:0]        frm_mem  [TABLE_ENTRIES * STACK_DEPTH];

    logic [31:0]        hash_q;
    logic [31:0]        pid_q;
    logic [DEPTH_W-1:0] dep_q;
    logic [63:0]        hits_q;
    logic [63:0]        frm_q;

    bstate_t            state_reg;
    job_t               job_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W:0]     probe_reg;
    logic [DEPTH_W-1:0] fi_reg;
    logic [63:0]        total_reg;
    logic [63:0]        drop_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    out_t               res_reg;
    out_t               out_reg;
    logic               out_valid_reg;

    logic               wr_slot;
    logic               wr_hits;
    logic [63:0]        hits_wdata;
    logic               wr_frm;
    logic [FADDR_W-1:0] faddr;
    logic               key_match;
    logic               last_fi;
    logic               out_free;

    assign faddr     = {idx_reg, fi_reg[FIDX_W-1:0]};
    assign pend_idx  = fi_reg[FIDX_W-1:0];
    assign key_match = valid_reg[idx_reg] && (hash_q == job_reg.hash)
                       && (pid_q == job_reg.pid) && (dep_q == job_reg.depth);
    assign last_fi   = ((fi_reg + DEPTH_W'(1)) == job_reg.depth);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pop       = (state_reg == B_IDLE) && !q_empty;
    assign done      = (state_reg == B_EMIT) && out_free && !job_reg.is_tick;

    always_comb
    begin
        wr_slot    = 1'b0;
        wr_hits    = 1'b0;
        hits_wdata = 64'd1;
        wr_frm     = 1'b0;
        if (state_reg == B_CMP)
        begin
            if (!valid_reg[idx_reg])
            begin
                wr_slot = 1'b1;
                wr_hits = 1'b1;
            end
            else if (key_match && (job_reg.depth == '0))
            begin
                wr_hits    = 1'b1;
                hits_wdata = hits_q + 64'd1;
            end
        end
        else if (state_reg == B_FCHK)
        begin
            if ((frm_q == pend_frame) && last_fi)
            begin
                wr_hits    = 1'b1;
                hits_wdata = hits_q + 64'd1;
            end
        end
        else if (state_reg == B_COPY)
        begin
            wr_frm = 1'b1;
        end
    end

    // Slot memories: one address per cycle, registered read
    always_ff @(posedge clk)
    begin
        hash_q <= hash_mem[idx_reg];
        pid_q  <= pid_mem[idx_reg];
        dep_q  <= dep_mem[idx_reg];
        hits_q <= hits_mem[idx_reg];
        frm_q  <= frm_mem[faddr];
        if (wr_slot)
        begin
            hash_mem[idx_reg] <= job_reg.hash;
            pid_mem[idx_reg]  <= job_reg.pid;
            dep_mem[idx_reg]  <= job_reg.depth;
        end
        if (wr_hits)
        begin
            hits_mem[idx_reg] <= hits_wdata;
        end
        if (wr_frm)
        begin
            frm_mem[faddr] <= pend_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            job_reg       <= '0;
            idx_reg       <= '0;
            probe_reg     <= '0;
            fi_reg        <= '0;
            total_reg     <= 64'd0;
            drop_reg      <= 64'd0;
            valid_reg     <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a new word when emitting, drop valid once the word is taken
            if ((state_reg == B_EMIT) && out_free && !clear)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear)
            begin
                state_reg <= B_IDLE;
                total_reg <= 64'd0;
                drop_reg  <= 64'd0;
                valid_reg <= '0;
            end
            else
            begin
                case (state_reg)
                    B_IDLE:
                    begin
                        if (!q_empty)
                        begin
                            job_reg   <= q_head;
                            idx_reg   <= q_head.hash[IDX_W-1:0];
                            probe_reg <= '0;
                            fi_reg    <= '0;
                            if (q_head.is_tick)
                            begin
                                res_reg   <= '{KIND_TICK, q_head.due, OC_NEW, 8'd0, 64'd0,
                                               total_reg, drop_reg};
                                state_reg <= B_EMIT;
                            end
                            else
                            begin
                                state_reg <= B_READ;
                            end
                        end
                    end
                    B_READ:
                    begin
                        state_reg <= B_CMP;
                    end
                    B_CMP:
                    begin
                        fi_reg <= '0;
                        if (!valid_reg[idx_reg])
                        begin
                            // empty slot: claim it, then copy the frames
                            valid_reg[idx_reg] <= 1'b1;
                            if (job_reg.depth == '0)
                            begin
                                total_reg <= total_reg + 64'd1;
                                res_reg   <= '{KIND_SAMPLE, 1'b0, OC_NEW, idx_reg, 64'd1,
                                               total_reg + 64'd1, drop_reg};
                                state_reg <= B_EMIT;
                            end
                            else
                            begin
                                state_reg <= B_COPY;
                            end
                        end
                        else if (key_match)
                        begin
                            if (job_reg.depth == '0)
                            begin
                                total_reg <= total_reg + 64'd1;
                                res_reg   <= '{KIND_SAMPLE, 1'b0, OC_HIT, idx_reg,
                                               hits_q + 64'd1, total_reg + 64'd1, drop_reg};
                                state_reg <= B_EMIT;
                            end
                            else
                            begin
                                state_reg <= B_FRD;
                            end
                        end
                        else if (probe_reg == (IDX_W + 1)'(TABLE_ENTRIES - 1))
                        begin
                            drop_reg  <= drop_reg + 64'd1;
                            res_reg   <= '{KIND_SAMPLE, 1'b0, OC_DROP, 8'd0, 64'd0,
                                           total_reg, drop_reg + 64'd1};
                            state_reg <= B_EMIT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            probe_reg <= probe_reg + (IDX_W + 1)'(1);
                            state_reg <= B_READ;
                        end
                    end
                    B_FRD:
                    begin
                        state_reg <= B_FCHK;
                    end
                    B_FCHK:
                    begin
                        if (frm_q != pend_frame)
                        begin
                            if (probe_reg == (IDX_W + 1)'(TABLE_ENTRIES - 1))
                            begin
                                drop_reg  <= drop_reg + 64'd1;
                                res_reg   <= '{KIND_SAMPLE, 1'b0, OC_DROP, 8'd0, 64'd0,
                                               total_reg, drop_reg + 64'd1};
                                state_reg <= B_EMIT;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + IDX_W'(1);
                                probe_reg <= probe_reg + (IDX_W + 1)'(1);
                                state_reg <= B_READ;
                            end
                        end
                        else if (last_fi)
                        begin
                            total_reg <= total_reg + 64'd1;
                            res_reg   <= '{KIND_SAMPLE, 1'b0, OC_HIT, idx_reg,
                                           hits_q + 64'd1, total_reg + 64'd1, drop_reg};
                            state_reg <= B_EMIT;
                        end
                        else
                        begin
                            fi_reg    <= fi_reg + DEPTH_W'(1);
                            state_reg <= B_FRD;
                        end
                    end
                    B_COPY:
                    begin
                        if (last_fi)
                        begin
                            total_reg <= total_reg + 64'd1;
                            res_reg   <= '{KIND_SAMPLE, 1'b0, OC_NEW, idx_reg, 64'd1,
                                           total_reg + 64'd1, drop_reg};
                            state_reg <= B_EMIT;
                        end
                        else
                        begin
                            fi_reg <= fi_reg + DEPTH_W'(1);
                        end
                    end
                    B_EMIT:
                    begin
                        if (out_free)
                        begin
                            out_reg   <= res_reg;
                            state_reg <= B_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= B_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

/* sv/stack_sample_hash_counter.sv */
// Stack sample hash counter.
// Input channel (in_valid / in_stall / in_data): one word per tick or per stack
// frame. A tick word always yields one result word telling whether a sample
// is due. Frame words carry a process id and an address, innermost first; the
// word flagged last_frame closes the sample and yields one result word with
// the table outcome (new, counted, dropped). Frames arriving while disabled
// are taken and dropped silently.
// Output channel (out_valid / out_stall / out_data): one registered word;
// while out_stall is high it holds, and the block keeps working up to that
// register, with a two-word queue between the front and the back end.
// Flow: a tick answer passes through the queue, the back end state machine
// and the output register. A stored frame is hashed in the front byte by
// byte through the one FNV multiplier, after the process id for the first
// frame of a sample. A closing frame then occupies the back end with a slot
// read and compare per probed slot plus a frame read and check per compared
// frame, or one write per copied frame on a new entry; the table walk bounds
// it at about 256 probes. New frames wait while a sample is in the back end.
// Config: write enable/sample_divider via cfg_we/cfg_index/cfg_data while idle.
// Writing enable 1 while it is 0 clears table, counters and divider count at once.
// Reset (rst_n low, async): disabled, divider 1, table empty, queue empty.
`timescale 1ns / 1ps
module stack_sample_hash_counter
    import ssh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic              enable_reg;
    logic [15:0]       divider_reg;
    logic              clear;
    logic              push;
    job_t              push_job;
    logic              q_full;
    logic              q_empty;
    job_t              q_head;
    logic              pop;
    logic              done;
    logic [FIDX_W-1:0] pend_idx;
    logic [63:0]       pend_frame;

    // Clear the run only on an enable rising edge
    assign clear = cfg_we && (cfg_index == CFG_ENABLE) && cfg_data[0] && !enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            divider_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_DIVIDER: divider_reg <= cfg_data;
                default:     enable_reg  <= enable_reg;
            endcase
        end
    end

    // Front: take words, run the divider, hash frames
    ssh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .enable     (enable_reg),
        .divider    (divider_reg),
        .clear      (clear),
        .push       (push),
        .push_job   (push_job),
        .q_full     (q_full),
        .done       (done),
        .pend_idx   (pend_idx),
        .pend_frame (pend_frame)
    );

    ssh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: probe the table, update counts, emit results in order
    ssh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .pop        (pop),
        .pend_idx   (pend_idx),
        .pend_frame (pend_frame),
        .done       (done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

/* sv/ssh_checker.sv */
`timescale 1ns / 1ps
module ssh_checker
    import ssh_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_TICK) |->
        (out_data.outcome == OC_NEW) && (out_data.slot_index == 8'd0)
        && (out_data.slot_count == 64'd0))
        else $error("tick answer carries sample fields");

    a_sample_due: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_SAMPLE) |-> !out_data.sample_due
        && (out_data.outcome != 2'd3))
        else $error("bad sample outcome word");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.outcome == OC_DROP) |->
        (out_data.slot_count == 64'd0) && (out_data.slot_index == 8'd0))
        else $error("dropped sample reports a slot");

    a_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_SAMPLE) && (out_data.outcome != OC_DROP) |->
        (out_data.slot_count != 64'd0) || (out_data.outcome == OC_HIT))
        else $error("recorded sample with zero count");

endmodule

bind stack_sample_hash_counter ssh_checker u_ssh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
